// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; defining NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant check failed");
`define CHK_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`else
`define CHK_ALWAYS(lbl, expr)
`define CHK_IMPLY(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/hslru_pkg.sv =====
// ----------------------------------------------------------------------------
// hslru_pkg
// Port widths, register indexes, scan kinds and the controller/datapath
// command and status groups of the hinted segmented LRU cache.
// ----------------------------------------------------------------------------
package hslru_pkg;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 72;
	localparam int KEY_PORT_W  = 64;
	localparam int HINT_W      = 8;
	localparam int CFG_W       = 7;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CAP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE = 1'b1;

	localparam logic [CFG_W-1:0] RST_TOTAL_CAP = 7'd64;
	localparam logic [CFG_W-1:0] RST_BASE_SIZE = 7'd4;

	localparam logic [1:0] SCAN_MATCH  = 2'd0;
	localparam logic [1:0] SCAN_OLDEST = 2'd1;
	localparam logic [1:0] SCAN_RANK   = 2'd2;

	typedef struct packed {
		logic       accept;
		logic       mode_check;
		logic       scan_start;
		logic [1:0] scan_kind;
		logic       scan_seg_cur;
		logic       set_err;
		logic       remove_hit;
		logic       evict_early;
		logic       place_write;
		logic       hold_victim;
		logic       move_write;
		logic       cur_dec;
		logic       rank_init;
		logic       rank_write;
		logic       rank_finish;
		logic       lru_check;
		logic       evict_final;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic found;
		logic err_cond;
		logic place_en;
		logic slot_free;
		logic clock_max;
		logic cur_zero;
		logic over_cur;
		logic over0;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/hslru_ctrl.sv =====
// ----------------------------------------------------------------------------
// hslru_ctrl
// Request sequencer: hit search, placement, cascade of overflows, final
// eviction from segment zero and recency renumbering.
// ----------------------------------------------------------------------------
module hslru_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  hslru_pkg::sts_t sts,
	output hslru_pkg::cmd_t cmd
);
	import hslru_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MCHK   = 4'd1;
	localparam logic [3:0] ST_HSCAN  = 4'd2;
	localparam logic [3:0] ST_PCHK   = 4'd3;
	localparam logic [3:0] ST_EVSCAN = 4'd4;
	localparam logic [3:0] ST_STAMP  = 4'd5;
	localparam logic [3:0] ST_RNEXT  = 4'd6;
	localparam logic [3:0] ST_RSCAN  = 4'd7;
	localparam logic [3:0] ST_CASC   = 4'd8;
	localparam logic [3:0] ST_MSCAN  = 4'd9;
	localparam logic [3:0] ST_LRUCHK = 4'd10;
	localparam logic [3:0] ST_F0CHK  = 4'd11;
	localparam logic [3:0] ST_FSCAN  = 4'd12;
	localparam logic [3:0] ST_FIN    = 4'd13;

	logic [3:0] state_q, state_d;
	logic       for_move_q, for_move_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d    = state_q;
		for_move_d = for_move_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_MCHK;
				end
			end
			ST_MCHK: begin
				cmd.mode_check = 1'b1;
				cmd.scan_start = 1'b1;
				cmd.scan_kind  = SCAN_MATCH;
				state_d        = ST_HSCAN;
			end
			ST_HSCAN: begin
				if (sts.scan_done) begin
					if (sts.err_cond) begin
						cmd.set_err = 1'b1;
						state_d     = ST_FIN;
					end else begin
						cmd.remove_hit = 1'b1;
						state_d        = ST_PCHK;
					end
				end
			end
			ST_PCHK: begin
				if (!sts.place_en) begin
					state_d = ST_LRUCHK;
				end else if (sts.slot_free) begin
					for_move_d = 1'b0;
					state_d    = ST_STAMP;
				end else begin
					cmd.scan_start = 1'b1;
					cmd.scan_kind  = SCAN_OLDEST;
					state_d        = ST_EVSCAN;
				end
			end
			ST_EVSCAN: begin
				if (sts.scan_done) begin
					if (sts.found) begin
						cmd.evict_early = 1'b1;
						for_move_d      = 1'b0;
						state_d         = ST_STAMP;
					end else begin
						state_d = ST_LRUCHK;
					end
				end
			end
			ST_STAMP: begin
				if (sts.clock_max) begin
					cmd.rank_init = 1'b1;
					state_d       = ST_RNEXT;
				end else if (for_move_q) begin
					cmd.move_write = 1'b1;
					state_d        = ST_CASC;
				end else begin
					cmd.place_write = 1'b1;
					state_d         = ST_CASC;
				end
			end
			ST_RNEXT: begin
				cmd.scan_start = 1'b1;
				cmd.scan_kind  = SCAN_RANK;
				state_d        = ST_RSCAN;
			end
			ST_RSCAN: begin
				if (sts.scan_done) begin
					if (sts.found) begin
						cmd.rank_write = 1'b1;
						state_d        = ST_RNEXT;
					end else begin
						cmd.rank_finish = 1'b1;
						state_d         = ST_STAMP;
					end
				end
			end
			ST_CASC: begin
				if (sts.cur_zero) begin
					state_d = ST_LRUCHK;
				end else if (sts.over_cur) begin
					cmd.scan_start   = 1'b1;
					cmd.scan_kind    = SCAN_OLDEST;
					cmd.scan_seg_cur = 1'b1;
					state_d          = ST_MSCAN;
				end else begin
					cmd.cur_dec = 1'b1;
				end
			end
			ST_MSCAN: begin
				if (sts.scan_done) begin
					if (sts.found) begin
						cmd.hold_victim = 1'b1;
						for_move_d      = 1'b1;
						state_d         = ST_STAMP;
					end else begin
						cmd.cur_dec = 1'b1;
						state_d     = ST_CASC;
					end
				end
			end
			ST_LRUCHK: begin
				cmd.lru_check = 1'b1;
				state_d       = ST_F0CHK;
			end
			ST_F0CHK: begin
				if (sts.over0) begin
					cmd.scan_start = 1'b1;
					cmd.scan_kind  = SCAN_OLDEST;
					state_d        = ST_FSCAN;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FSCAN: begin
				if (sts.scan_done) begin
					cmd.evict_final = sts.found;
					state_d         = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			for_move_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			for_move_q <= for_move_d;
		end
	end

endmodule

// ===== rtl/core/hslru_dp.sv =====
// ----------------------------------------------------------------------------
// hslru_dp
// Entry memory with a sequential scan engine, valid and rank flags,
// segment occupancy, segment layout, recency clock and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hslru_dp #(
	parameter int CAPACITY     = 64,
	parameter int MAX_SEGMENTS = 8,
	parameter int KEY_WIDTH    = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  hslru_pkg::cmd_t                      cmd,
	output hslru_pkg::sts_t                      sts,
	input  logic [hslru_pkg::KEY_PORT_W-1:0]     in_key,
	input  logic [hslru_pkg::HINT_W-1:0]         in_hint,
	input  logic                                 cfg_we,
	input  logic [hslru_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hslru_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic                                 out_hit,
	output logic                                 out_ev,
	output logic [hslru_pkg::KEY_PORT_W-1:0]     out_evkey,
	output logic                                 out_err,
	output logic                                 out_mode
);
	import hslru_pkg::*;

	localparam int IW  = $clog2(CAPACITY);
	localparam int OW  = $clog2(CAPACITY + 1);
	localparam int SW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int SCW = $clog2(MAX_SEGMENTS + 1);
	localparam int RW  = 32;
	localparam int WW  = KEY_WIDTH + SW + RW;
	localparam int PW  = ((OW > CFG_W) ? OW : CFG_W) + 3;
	// floor(cap * 9 / 10) as one constant product and a shift.
	localparam logic [31:0] THR_MUL = 32'd471861;
	localparam int THR_SHIFT = 19;

	// Configuration and layout.
	logic [CFG_W-1:0] tc_q, bs_q;
	logic [OW-1:0]    lim_d [MAX_SEGMENTS];
	logic [OW-1:0]    lim_q [MAX_SEGMENTS];
	logic [SCW-1:0]   sc_d, sc_q;
	logic [OW-1:0]    cap_d, cap_q, thr_d, thr_q;
	logic [PW-1:0]    left, piece;
	logic             stop;
	logic [31:0]      thr_prod;

	always_comb begin
		if (tc_q == '0) begin
			cap_d = OW'(1);
		end else if (32'(tc_q) > CAPACITY) begin
			cap_d = OW'(CAPACITY);
		end else begin
			cap_d = OW'(tc_q);
		end
		thr_prod = 32'(cap_d) * THR_MUL;
		thr_d    = OW'(thr_prod >> THR_SHIFT);
		left  = PW'(cap_d);
		piece = (bs_q == '0) ? PW'(1) : PW'(bs_q);
		stop  = 1'b0;
		sc_d  = SCW'(1);
		for (int k = 0; k < MAX_SEGMENTS; k++) begin
			lim_d[k] = '0;
			if (!stop) begin
				if (k < MAX_SEGMENTS - 1 && left > piece) begin
					lim_d[k] = OW'(piece);
					left     = left - piece;
					piece    = piece << 2;
					sc_d     = SCW'(k + 2);
				end else begin
					lim_d[k] = OW'(left);
					stop     = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		lim_q <= lim_d;
		sc_q  <= sc_d;
		cap_q <= cap_d;
		thr_q <= thr_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= RST_TOTAL_CAP;
			bs_q <= RST_BASE_SIZE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOTAL_CAP: tc_q <= cfg_wdata;
				REG_BASE_SIZE: bs_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Request registers.
	logic [KEY_WIDTH-1:0] key_q;
	logic [HINT_W-1:0]    hint_q;
	logic                 hint_mode_q, early_q, err_q, ev_q;
	logic [KEY_WIDTH-1:0] ev_key_q;

	// Entry memory and scan engine.
	logic [WW-1:0]        mem [CAPACITY];
	logic [WW-1:0]        rd_q;
	logic                 mem_we;
	logic [IW-1:0]        mem_wa;
	logic [WW-1:0]        mem_wd;
	logic [CAPACITY-1:0]  valid_q, rdone_q;
	logic                 scan_act_q, iss_s1, last_s1, scan_done_q;
	logic [IW-1:0]        cnt_q, idx_s1;
	logic [1:0]           kind_q;
	logic [SW-1:0]        sel_q;
	logic [KEY_WIDTH-1:0] rd_key;
	logic [SW-1:0]        rd_seg;
	logic [RW-1:0]        rd_rec;

	logic                 hit_found_q, inv_found_q, found_q;
	logic [IW-1:0]        hit_idx_q, inv_idx_q, best_idx_q, slot_q, vic_idx_q;
	logic [SW-1:0]        hit_seg_q, best_seg_q, cur_q, cur_m1, tgt;
	logic [KEY_WIDTH-1:0] best_key_q, vic_key_q;
	logic [RW-1:0]        best_rec_q, clk_q;
	logic [OW-1:0]        rank_q;

	logic [OW-1:0]        occ_q [MAX_SEGMENTS];
	logic [OW-1:0]        occ_d [MAX_SEGMENTS];
	logic [OW-1:0]        tot_q, tot_d;

	logic                 ov_q, ov_hit_q, ov_ev_q, ov_err_q, ov_mode_q;
	logic [KEY_PORT_W-1:0] ov_evkey_q;

	logic                 v_s1, older, take, lt_sc;

	assign rd_key = rd_q[WW-1 -: KEY_WIDTH];
	assign rd_seg = rd_q[RW +: SW];
	assign rd_rec = rd_q[RW-1:0];
	assign cur_m1 = cur_q - SW'(1);

	assign lt_sc = (hint_q[HINT_W-2:0] < 7'(sc_q));
	assign tgt   = (hint_mode_q && !hint_q[HINT_W-1] && lt_sc) ? SW'(hint_q[HINT_W-2:0])
	                                                           : SW'(sc_q - SCW'(1));

	assign v_s1  = valid_q[idx_s1];
	assign older = !found_q || (rd_rec < best_rec_q);
	always_comb begin
		take = 1'b0;
		if (iss_s1 && v_s1 && older) begin
			case (kind_q)
				SCAN_OLDEST: take = (rd_seg == sel_q);
				SCAN_RANK:   take = !rdone_q[idx_s1];
				default:     take = 1'b0;
			endcase
		end
	end

	// The single write port serves placement, cascade moves and renumbering.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot_q;
		mem_wd = {key_q, tgt, clk_q};
		if (cmd.place_write) begin
			mem_we = 1'b1;
		end else if (cmd.move_write) begin
			mem_we = 1'b1;
			mem_wa = vic_idx_q;
			mem_wd = {vic_key_q, cur_m1, clk_q};
		end else if (cmd.rank_write) begin
			mem_we = 1'b1;
			mem_wa = best_idx_q;
			mem_wd = {best_key_q, best_seg_q, RW'(rank_q)};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[cnt_q];
	end

	always_comb begin
		occ_d = occ_q;
		tot_d = tot_q;
		if (cmd.remove_hit && hit_found_q) begin
			occ_d[hit_seg_q] = occ_d[hit_seg_q] - OW'(1);
			tot_d = tot_d - OW'(1);
		end
		if (cmd.evict_early || cmd.evict_final) begin
			occ_d[0] = occ_d[0] - OW'(1);
			tot_d = tot_d - OW'(1);
		end
		if (cmd.place_write) begin
			occ_d[tgt] = occ_d[tgt] + OW'(1);
			tot_d = tot_d + OW'(1);
		end
		if (cmd.move_write) begin
			occ_d[cur_q]  = occ_d[cur_q] - OW'(1);
			occ_d[cur_m1] = occ_d[cur_m1] + OW'(1);
		end
		if (cfg_we) begin
			for (int s = 0; s < MAX_SEGMENTS; s++) begin
				occ_d[s] = '0;
			end
			tot_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_act_q  <= 1'b0;
			iss_s1      <= 1'b0;
			last_s1     <= 1'b0;
			scan_done_q <= 1'b0;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			hit_found_q <= 1'b0;
			inv_found_q <= 1'b0;
			valid_q     <= '0;
			rdone_q     <= '0;
			hint_mode_q <= 1'b0;
			clk_q       <= '0;
			tot_q       <= '0;
			for (int s = 0; s < MAX_SEGMENTS; s++) begin
				occ_q[s] <= '0;
			end
			ov_q        <= 1'b0;
		end else begin
			iss_s1  <= scan_act_q;
			last_s1 <= scan_act_q && (cnt_q == IW'(CAPACITY - 1));
			if (scan_act_q) begin
				if (cnt_q == IW'(CAPACITY - 1)) begin
					scan_act_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + IW'(1);
				end
			end
			if (iss_s1 && last_s1) begin
				scan_done_q <= 1'b1;
			end
			if (iss_s1 && kind_q == SCAN_MATCH) begin
				if (v_s1 && rd_key == key_q && !hit_found_q) begin
					hit_found_q <= 1'b1;
				end
				if (!v_s1 && !inv_found_q) begin
					inv_found_q <= 1'b1;
				end
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (cmd.scan_start) begin
				scan_act_q  <= 1'b1;
				scan_done_q <= 1'b0;
				cnt_q       <= '0;
				found_q     <= 1'b0;
				if (cmd.scan_kind == SCAN_MATCH) begin
					hit_found_q <= 1'b0;
					inv_found_q <= 1'b0;
				end
			end

			if (cmd.remove_hit && hit_found_q) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
			if (cmd.evict_early || cmd.evict_final) begin
				valid_q[best_idx_q] <= 1'b0;
			end
			if (cmd.place_write) begin
				valid_q[slot_q] <= 1'b1;
			end
			if (cmd.rank_init) begin
				rdone_q <= '0;
			end
			if (cmd.rank_write) begin
				rdone_q[best_idx_q] <= 1'b1;
			end

			occ_q <= occ_d;
			tot_q <= tot_d;

			if (cmd.place_write || cmd.move_write) begin
				clk_q <= clk_q + RW'(1);
			end else if (cmd.rank_finish) begin
				clk_q <= RW'(rank_q);
			end

			// Hint mode drops out below nine tenths of capacity and starts
			// when an LRU placement leaves the cache exactly full.
			if (cmd.mode_check && hint_mode_q && tot_q < thr_q) begin
				hint_mode_q <= 1'b0;
			end else if (cmd.lru_check && !hint_mode_q &&
			             (tot_q + OW'(early_q)) == cap_q) begin
				hint_mode_q <= 1'b1;
			end

			if (cmd.emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end

			if (cfg_we) begin
				valid_q     <= '0;
				hint_mode_q <= 1'b0;
				clk_q       <= '0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (cmd.scan_start) begin
			kind_q <= cmd.scan_kind;
			sel_q  <= cmd.scan_seg_cur ? cur_q : '0;
		end
		if (iss_s1 && kind_q == SCAN_MATCH) begin
			if (v_s1 && rd_key == key_q && !hit_found_q) begin
				hit_idx_q <= idx_s1;
				hit_seg_q <= rd_seg;
			end
			if (!v_s1 && !inv_found_q) begin
				inv_idx_q <= idx_s1;
			end
		end
		if (take) begin
			best_idx_q <= idx_s1;
			best_key_q <= rd_key;
			best_seg_q <= rd_seg;
			best_rec_q <= rd_rec;
		end
		if (cmd.accept) begin
			key_q   <= in_key[KEY_WIDTH-1:0];
			hint_q  <= in_hint;
			early_q <= 1'b0;
			err_q   <= 1'b0;
			ev_q    <= 1'b0;
		end
		if (cmd.set_err) begin
			err_q <= 1'b1;
		end
		// The first free slot after taking out the hit entry.
		if (cmd.remove_hit) begin
			slot_q <= (inv_found_q && (!hit_found_q || inv_idx_q < hit_idx_q)) ? inv_idx_q
			                                                                  : hit_idx_q;
		end
		if (cmd.evict_early) begin
			early_q <= 1'b1;
			slot_q  <= best_idx_q;
		end
		if (cmd.evict_early || cmd.evict_final) begin
			ev_q     <= 1'b1;
			ev_key_q <= best_key_q;
		end
		if (cmd.place_write) begin
			cur_q <= tgt;
		end else if (cmd.move_write || cmd.cur_dec) begin
			cur_q <= cur_m1;
		end
		if (cmd.hold_victim) begin
			vic_idx_q <= best_idx_q;
			vic_key_q <= best_key_q;
		end
		if (cmd.rank_init) begin
			rank_q <= '0;
		end else if (cmd.rank_write) begin
			rank_q <= rank_q + OW'(1);
		end
		if (cmd.emit) begin
			ov_hit_q   <= hit_found_q;
			ov_ev_q    <= ev_q;
			ov_evkey_q <= ev_q ? KEY_PORT_W'(ev_key_q) : '0;
			ov_err_q   <= err_q;
			ov_mode_q  <= hint_mode_q;
		end
	end

	assign sts.scan_done = scan_done_q;
	assign sts.found     = found_q;
	assign sts.err_cond  = hint_mode_q && hint_q[HINT_W-1];
	assign sts.place_en  = !hint_mode_q ||
	                       (!hint_q[HINT_W-1] && ({1'b0, hint_q[HINT_W-2:0]} <= 8'(sc_q)));
	assign sts.slot_free = inv_found_q || hit_found_q;
	assign sts.clock_max = &clk_q;
	assign sts.cur_zero  = (cur_q == '0);
	assign sts.over_cur  = occ_q[cur_q] > lim_q[cur_q];
	assign sts.over0     = occ_q[0] > lim_q[0];
	assign sts.out_free  = !ov_q || out_ready;

	assign out_valid = ov_q;
	assign out_hit   = ov_hit_q;
	assign out_ev    = ov_ev_q;
	assign out_evkey = ov_evkey_q;
	assign out_err   = ov_err_q;
	assign out_mode  = ov_mode_q;

	`CHK_ALWAYS(a_tot_in_range, tot_q <= OW'(CAPACITY))
	`CHK_IMPLY(a_no_write_in_scan, mem_we, !scan_act_q && !iss_s1)
	`CHK_IMPLY(a_evkey_zero, ov_q && !ov_ev_q, ov_evkey_q == '0)

endmodule

// ===== rtl/core/hinted_segmented_lru_cache.sv =====
// ----------------------------------------------------------------------------
// hinted_segmented_lru_cache
// Segmented LRU cache with hint-directed placement and eviction reporting.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    key, hint
//   m_*      out  m_tvalid/m_tready    hit, evicted_valid, evicted_key, ...
//   cfg_*    in   cfg_we               total_capacity, base_segment_size
//
// Every step that looks at the entries walks the entry memory through its
// single read port, one entry a cycle. An item takes one walk to find the
// key, up to one to free a slot, one per overflowing segment of the cascade
// and one for segment zero. When the 32-bit recency clock is full, a
// renumbering adds one walk per valid entry and one more. Reset needs no
// clearing pass. A new item is taken while the previous result waits in the
// output register.
// ----------------------------------------------------------------------------
module hinted_segmented_lru_cache #(
	parameter int CAPACITY     = 64,
	parameter int MAX_SEGMENTS = 8,
	parameter int KEY_WIDTH    = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// key [63:0], hint [71:64]
	input  logic [hslru_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// hit [0], evicted_valid [1], evicted_key [65:2], hint_error [66],
	// hint_mode_on [67], zero [71:68]
	output logic [hslru_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                 cfg_we,
	input  logic [hslru_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hslru_pkg::CFG_W-1:0]          cfg_wdata
);
	import hslru_pkg::*;

	cmd_t                  cmd;
	sts_t                  sts;
	logic                  o_hit, o_ev, o_err, o_mode;
	logic [KEY_PORT_W-1:0] o_evkey;

	hslru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hslru_dp #(
		.CAPACITY     (CAPACITY),
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.KEY_WIDTH    (KEY_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_key    (s_tdata[KEY_PORT_W-1:0]),
		.in_hint   (s_tdata[KEY_PORT_W +: HINT_W]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_hit   (o_hit),
		.out_ev    (o_ev),
		.out_evkey (o_evkey),
		.out_err   (o_err),
		.out_mode  (o_mode)
	);

	assign m_tdata = {4'b0000, o_mode, o_err, o_evkey, o_ev, o_hit};

endmodule
